### rtl/share_submit_framer_defines.svh
// ----------------------------------------------------------------------------
// Share submit framer: assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef SHARE_SUBMIT_FRAMER_DEFINES_SVH
`define SHARE_SUBMIT_FRAMER_DEFINES_SVH

// Same-cycle implication, switched off while reset is low
`define SSCF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("share_submit_framer: property violated");

// Next-cycle implication, switched off while reset is low
`define SSCF_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("share_submit_framer: property violated");

// Next-cycle implication that also holds across reset
`define SSCF_ASSERT_NXT_ALWAYS(lbl, clk_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("share_submit_framer: property violated");

`endif

### rtl/sscf_pkg.sv
// ----------------------------------------------------------------------------
// Share submit framer package
// Types, constants and the frame byte selector shared by the framer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sscf_pkg;

  localparam int NUM_REGS        = 5;
  localparam int REG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 8;
  localparam int HIST_DEPTH      = 3;
  localparam int BASE_LEN        = 15;
  localparam int WORD_LEN        = 4;
  localparam int FRAME_LEN_W     = 5;
  localparam int DEF_QUEUE_DEPTH = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAGIC        = 3'd0,
    REG_CMD_PLAIN    = 3'd1,
    REG_CMD_TIME     = 3'd2,
    REG_CMD_VER      = 3'd3,
    REG_CMD_TIME_VER = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_NOTICE = 1'b0,
    OP_SHARE  = 1'b1
  } op_t;

  // One frame waiting to be serialised
  typedef struct packed {
    logic [7:0]             magic;
    logic [7:0]             cmd;
    logic [FRAME_LEN_W-1:0] len;
    logic                   with_time;
    logic [7:0]             job_id;
    logic [15:0]            link_id;
    logic [31:0]            aux_nonce;
    logic [31:0]            share_nonce;
    logic [31:0]            ntime;
    logic [31:0]            version_mask;
  } desc_t;

  // Byte of the frame at a given position, multi-byte fields little-endian
  function automatic logic [7:0] frame_byte_at(desc_t d, logic [FRAME_LEN_W-1:0] idx);
    logic [31:0] tail0;
    logic [7:0]  b;
    tail0 = d.with_time ? d.ntime : d.version_mask;
    case (idx)
      5'd0:    b = d.magic;
      5'd1:    b = d.cmd;
      5'd2:    b = {{(8-FRAME_LEN_W){1'b0}}, d.len};
      5'd3:    b = 8'h00;
      5'd4:    b = d.job_id;
      5'd5:    b = d.link_id[7:0];
      5'd6:    b = d.link_id[15:8];
      5'd7:    b = d.aux_nonce[7:0];
      5'd8:    b = d.aux_nonce[15:8];
      5'd9:    b = d.aux_nonce[23:16];
      5'd10:   b = d.aux_nonce[31:24];
      5'd11:   b = d.share_nonce[7:0];
      5'd12:   b = d.share_nonce[15:8];
      5'd13:   b = d.share_nonce[23:16];
      5'd14:   b = d.share_nonce[31:24];
      5'd15:   b = tail0[7:0];
      5'd16:   b = tail0[15:8];
      5'd17:   b = tail0[23:16];
      5'd18:   b = tail0[31:24];
      5'd19:   b = d.version_mask[7:0];
      5'd20:   b = d.version_mask[15:8];
      5'd21:   b = d.version_mask[23:16];
      5'd22:   b = d.version_mask[31:24];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/share_submit_framer.sv
// A share's first frame byte passes the queue entry, the serialiser's descriptor
// register and the output register before it is shown. A share frame is 15, 19 or
// 23 bytes, sent one byte per cycle while popped; notices and fake shares make none.
// Input accepts while the descriptor queue has room, so it runs ahead of output.
// Reset (synchronous, active low) clears registers, history, queue and output.
// ----------------------------------------------------------------------------
// Share submit framer: top level
// Front end, descriptor queue and serialiser for binary share frames.
// ----------------------------------------------------------------------------
`default_nettype none

module share_submit_framer #(
  parameter int QUEUE_DEPTH = sscf_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [sscf_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [sscf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic                            in_opcode,
  input  wire logic [7:0]                      in_job_id,
  input  wire logic [31:0]                     in_ntime,
  input  wire logic [31:0]                     in_aux_nonce,
  input  wire logic [31:0]                     in_share_nonce,
  input  wire logic [31:0]                     in_version_mask,
  input  wire logic                            in_fake_job,
  input  wire logic [15:0]                     in_link_id,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [7:0]                           out_frame_byte,
  output logic                                 out_last_byte
);
  import sscf_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  desc_t q_in_desc;
  desc_t q_head_desc;

  assign in_full = q_full;

  sscf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_opcode       (in_opcode),
    .in_job_id       (in_job_id),
    .in_ntime        (in_ntime),
    .in_aux_nonce    (in_aux_nonce),
    .in_share_nonce  (in_share_nonce),
    .in_version_mask (in_version_mask),
    .in_fake_job     (in_fake_job),
    .in_link_id      (in_link_id),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_desc          (q_in_desc)
  );

  sscf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_in_desc),
    .full      (q_full),
    .pop       (q_pop),
    .head_desc (q_head_desc),
    .empty     (q_empty)
  );

  sscf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_desc         (q_head_desc),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

`default_nettype wire

### rtl/sscf_front.sv
// ----------------------------------------------------------------------------
// Share submit framer: front end
// Holds the registers and the notice history, classifies each item and
// builds a frame descriptor for every genuine share.
// ----------------------------------------------------------------------------
`default_nettype none

module sscf_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [sscf_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [sscf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_push,
  input  wire logic                            in_opcode,
  input  wire logic [7:0]                      in_job_id,
  input  wire logic [31:0]                     in_ntime,
  input  wire logic [31:0]                     in_aux_nonce,
  input  wire logic [31:0]                     in_share_nonce,
  input  wire logic [31:0]                     in_version_mask,
  input  wire logic                            in_fake_job,
  input  wire logic [15:0]                     in_link_id,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output sscf_pkg::desc_t                      q_desc
);
  import sscf_pkg::*;

  logic [CFG_DATA_W-1:0] cfg_r   [NUM_REGS];
  logic [7:0]            hist_id_r [HIST_DEPTH];
  logic [31:0]           hist_tm_r [HIST_DEPTH];

  logic       accept;
  logic       is_notice;
  logic       known;
  logic       with_time;
  logic       with_ver;
  logic [7:0] cmd;
  logic [FRAME_LEN_W-1:0] len;

  assign accept    = in_push && !q_full;
  assign is_notice = (op_t'(in_opcode) == OP_NOTICE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < REG_IDX_W'(NUM_REGS))) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // Shift history on a notice: oldest drops out, newest goes on top
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_id_r[i] <= '0;
        hist_tm_r[i] <= '0;
      end
    end else if (accept && is_notice) begin
      for (int i = 0; i < HIST_DEPTH - 1; i++) begin
        hist_id_r[i] <= hist_id_r[i+1];
        hist_tm_r[i] <= hist_tm_r[i+1];
      end
      hist_id_r[HIST_DEPTH-1] <= in_job_id;
      hist_tm_r[HIST_DEPTH-1] <= in_ntime;
    end
  end

  always_comb begin
    known = 1'b0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      if ((hist_id_r[i] == in_job_id) && (hist_tm_r[i] == in_ntime)) begin
        known = 1'b1;
      end
    end
  end

  assign with_time = !known;
  assign with_ver  = (in_version_mask != 32'd0);

  always_comb begin
    case ({with_time, with_ver})
      2'b11:   cmd = cfg_r[REG_CMD_TIME_VER];
      2'b10:   cmd = cfg_r[REG_CMD_TIME];
      2'b01:   cmd = cfg_r[REG_CMD_VER];
      default: cmd = cfg_r[REG_CMD_PLAIN];
    endcase
  end

  assign len = FRAME_LEN_W'(BASE_LEN)
             + (with_time ? FRAME_LEN_W'(WORD_LEN) : '0)
             + (with_ver  ? FRAME_LEN_W'(WORD_LEN) : '0);

  // Fake shares and notices produce nothing downstream
  assign q_push = accept && !is_notice && !in_fake_job;

  always_comb begin
    q_desc.magic        = cfg_r[REG_MAGIC];
    q_desc.cmd          = cmd;
    q_desc.len          = len;
    q_desc.with_time    = with_time;
    q_desc.job_id       = in_job_id;
    q_desc.link_id      = in_link_id;
    q_desc.aux_nonce    = in_aux_nonce;
    q_desc.share_nonce  = in_share_nonce;
    q_desc.ntime        = in_ntime;
    q_desc.version_mask = in_version_mask;
  end

endmodule

`default_nettype wire

### rtl/sscf_queue.sv
// ----------------------------------------------------------------------------
// Share submit framer: descriptor queue
// Short first-in first-out buffer between the front end and the serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

module sscf_queue #(
  parameter int DEPTH = sscf_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire sscf_pkg::desc_t  push_desc,
  output logic                  full,
  input  wire logic             pop,
  output sscf_pkg::desc_t       head_desc,
  output logic                  empty
);
  import sscf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t            entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_desc = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

### rtl/sscf_back.sv
// ----------------------------------------------------------------------------
// Share submit framer: serialiser
// Takes frame descriptors from the queue and sends them one byte per cycle,
// while the receiver keeps popping, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sscf_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire sscf_pkg::desc_t  q_desc,
  output logic                  q_pop,
  input  wire logic             out_pop,
  output logic                  out_empty,
  output logic [7:0]            out_frame_byte,
  output logic                  out_last_byte
);
  import sscf_pkg::*;

  desc_t                  cur_r, cur_nxt;
  logic                   busy_r, busy_nxt;
  logic [FRAME_LEN_W-1:0] idx_r, idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_byte_r, out_byte_nxt;
  logic                   out_last_r, out_last_nxt;

  logic emit;
  logic last_now;
  logic load;

  // Advance when the output stage is free or being drained this cycle
  assign emit     = busy_r && (!out_valid_r || out_pop);
  assign last_now = (idx_r == (cur_r.len - FRAME_LEN_W'(1)));
  // Fetch the next frame in the same cycle as the current last byte
  assign load     = !q_empty && (!busy_r || (emit && last_now));
  assign q_pop    = load;

  always_comb begin
    cur_nxt       = cur_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = frame_byte_at(cur_r, idx_r);
      out_last_nxt  = last_now;
      idx_nxt       = idx_r + FRAME_LEN_W'(1);
      if (last_now) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      cur_nxt  = q_desc;
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_empty      = !out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

endmodule

`default_nettype wire

### rtl/sscf_checker.sv
// ----------------------------------------------------------------------------
// Share submit framer: port checker
// Watches the result port, checks reset and stall behaviour and checks frame length against the bytes sent.
// ----------------------------------------------------------------------------
`default_nettype none

`include "share_submit_framer_defines.svh"

module sscf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_push,
  input wire logic       in_full,
  input wire logic       out_pop,
  input wire logic       out_empty,
  input wire logic [7:0] out_frame_byte,
  input wire logic       out_last_byte
);

  logic [4:0] cnt_r, cnt_nxt;
  logic [7:0] len_r, len_nxt;
  logic       xfer;
  logic       unused_in_push;
  logic       stall;
  logic [8:0] out_word;
  logic       reset_ok;
  logic       len_ok;
  logic       last_ok;

  assign xfer           = out_pop && !out_empty;
  assign unused_in_push = in_push;
  assign stall          = !out_empty && !out_pop;
  assign out_word       = {out_last_byte, out_frame_byte};
  assign reset_ok       = out_empty && !in_full && !unused_in_push || out_empty && !in_full;
  assign len_ok         = (out_frame_byte == 8'd15) || (out_frame_byte == 8'd19)
                       || (out_frame_byte == 8'd23);
  assign last_ok        = (({3'b000, cnt_r} + 8'd1) == len_r);

  // Count bytes of the current frame, capture its length field
  always_comb begin
    cnt_nxt = cnt_r;
    len_nxt = len_r;
    if (xfer) begin
      cnt_nxt = out_last_byte ? 5'd0 : cnt_r + 5'd1;
      if (cnt_r == 5'd2) begin
        len_nxt = out_frame_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      len_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
    end
  end

  `SSCF_ASSERT_NXT_ALWAYS(a_reset_clears, clk, !rst_n, reset_ok)

  `SSCF_ASSERT_NXT(a_stall_holds, clk, rst_n, stall, !out_empty && $stable(out_word))

  `SSCF_ASSERT_IMP(a_len_legal, clk, rst_n, xfer && (cnt_r == 5'd2), len_ok)

  `SSCF_ASSERT_IMP(a_last_matches_len, clk, rst_n, xfer && out_last_byte, last_ok)

endmodule

bind share_submit_framer sscf_checker u_sscf_checker (.*);

`default_nettype wire

### tb/share_submit_framer_tb.sv
// ----------------------------------------------------------------------------
// Share submit framer testbench
// Drives job notices and share submissions through the input queue port and
// checks every frame byte against a local predictor of the job history and
// the frame layout. It starts with a stimulus table, then runs random traffic
// in three idling patterns. The registers are reloaded between phases.
// ----------------------------------------------------------------------------

module share_submit_framer_tb;
  import sscf_pkg::*;

  localparam int LEN_FREE      = -1;      // no frame length typed into the row
  localparam int DIR_ROWS      = 22;
  localparam int SETTLE_CYCLES = 6;
  localparam int RX_HOLD       = 80;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    op_t         op;
    logic [7:0]  job_id;
    logic [31:0] ntime;
    logic [31:0] aux_nonce;
    logic [31:0] share_nonce;
    logic [31:0] version_mask;
    logic        fake_job;
    logic [15:0] link_id;
    int          want_len;
  } submit_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_push;
  logic                  in_full;
  logic                  in_opcode;
  logic [7:0]            in_job_id;
  logic [31:0]           in_ntime;
  logic [31:0]           in_aux_nonce;
  logic [31:0]           in_share_nonce;
  logic [31:0]           in_version_mask;
  logic                  in_fake_job;
  logic [15:0]           in_link_id;
  logic                  out_empty;
  logic                  out_pop;
  logic [7:0]            out_frame_byte;
  logic                  out_last_byte;

  // Predictor state: register copies and job history, entry 2 newest
  logic [7:0]  reg_copy [NUM_REGS];
  logic [7:0]  hist_job [HIST_DEPTH];
  logic [31:0] hist_time [HIST_DEPTH];
  frame_byte_t frame_q [$];

  int  err_cnt       = 0;
  int  cycle_cnt     = 0;
  int  tx_idle_pct   = 0;
  int  rx_idle_pct   = 0;
  bit  rx_hold_req   = 1'b0;
  int  n_items       = 0;
  int  n_notices     = 0;
  int  n_fakes       = 0;
  int  n_frames      = 0;
  int  n_bytes       = 0;
  int  n_stalls      = 0;

  submit_t dir_tab [DIR_ROWS] = '{
    // empty history after reset, registers still at reset value
    '{OP_SHARE,  8'h00, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      1'b0, 16'h0000, 15},
    '{OP_SHARE,  8'h00, 32'h0000_0001, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0000,
      1'b0, 16'h0102, 19},
    // extremes
    '{OP_SHARE,  8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b0, 16'hFFFF, 19},
    '{OP_SHARE,  8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b0, 16'hFFFF, 23},
    // notice with every unused field set: only job id and time count
    '{OP_NOTICE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b1, 16'hFFFF, 0},
    '{OP_SHARE,  8'hFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      1'b0, 16'h0000, 15},
    '{OP_SHARE,  8'hFF, 32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      1'b0, 16'h0000, 19},
    '{OP_SHARE,  8'hFE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      1'b0, 16'h0000, 19},
    // fill the history, then hit each entry
    '{OP_NOTICE, 8'h12, 32'h1111_1111, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      1'b0, 16'h0000, 0},
    '{OP_NOTICE, 8'h34, 32'h2222_2222, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      1'b0, 16'h0000, 0},
    '{OP_SHARE,  8'h34, 32'h2222_2222, 32'hCAFE_0001, 32'h0BAD_F00D, 32'h0000_0000,
      1'b0, 16'h8001, 15},
    '{OP_SHARE,  8'h12, 32'h1111_1111, 32'h0000_0002, 32'h0000_0003, 32'h0000_0001,
      1'b0, 16'h0010, 19},
    '{OP_SHARE,  8'hFF, 32'hFFFF_FFFF, 32'h0000_0004, 32'h0000_0005, 32'h8000_0000,
      1'b0, 16'h0020, 19},
    // oldest entry drops out
    '{OP_NOTICE, 8'h56, 32'h3333_3333, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      1'b0, 16'h0000, 0},
    '{OP_SHARE,  8'hFF, 32'hFFFF_FFFF, 32'h0000_0006, 32'h0000_0007, 32'h0000_0000,
      1'b0, 16'h0030, 19},
    // fake shares: no output, history untouched
    '{OP_SHARE,  8'h56, 32'h3333_3333, 32'h0000_0008, 32'h0000_0009, 32'h0000_0000,
      1'b1, 16'h0040, 0},
    '{OP_SHARE,  8'h00, 32'h0000_0000, 32'h0000_000A, 32'h0000_000B, 32'hDEAD_BEEF,
      1'b1, 16'h0050, 0},
    '{OP_SHARE,  8'h56, 32'h3333_3333, 32'h0000_000C, 32'h0000_000D, 32'h0000_0000,
      1'b0, 16'h0060, 15},
    '{OP_NOTICE, 8'h00, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      1'b0, 16'h0000, 0},
    '{OP_SHARE,  8'h00, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      1'b0, 16'h0000, 15},
    '{OP_SHARE,  8'h5A, 32'hA5A5_A5A5, 32'h5555_AAAA, 32'hAAAA_5555, 32'h0F0F_0F0F,
      1'b0, 16'hA55A, LEN_FREE},
    '{OP_SHARE,  8'h34, 32'h2222_2222, 32'h0246_8ACE, 32'h1357_9BDF, 32'h7654_3210,
      1'b0, 16'h3C3C, LEN_FREE}
  };

  share_submit_framer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_opcode       (in_opcode),
    .in_job_id       (in_job_id),
    .in_ntime        (in_ntime),
    .in_aux_nonce    (in_aux_nonce),
    .in_share_nonce  (in_share_nonce),
    .in_version_mask (in_version_mask),
    .in_fake_job     (in_fake_job),
    .in_link_id      (in_link_id),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_frame_byte  (out_frame_byte),
    .out_last_byte   (out_last_byte)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d frame bytes outstanding", $time, frame_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void queue_byte(input logic [7:0] b);
    frame_q.push_back('{data: b, last: 1'b0});
  endfunction

  function automatic void queue_word(input logic [31:0] w);
    queue_byte(w[7:0]);
    queue_byte(w[15:8]);
    queue_byte(w[23:16]);
    queue_byte(w[31:24]);
  endfunction

  // Apply one accepted item to the history and queue the frame it yields
  function automatic int build_frame(input submit_t it);
    logic        known;
    logic        add_time;
    logic        add_ver;
    logic [7:0]  cmd;
    logic [15:0] len;
    int          k;
    known = 1'b0;
    if (it.op == OP_NOTICE) begin
      for (k = 0; k < HIST_DEPTH - 1; k++) begin
        hist_job[k]  = hist_job[k+1];
        hist_time[k] = hist_time[k+1];
      end
      hist_job[HIST_DEPTH-1]  = it.job_id;
      hist_time[HIST_DEPTH-1] = it.ntime;
      return 0;
    end
    if (it.fake_job) return 0;
    for (k = 0; k < HIST_DEPTH; k++)
      if (hist_job[k] == it.job_id && hist_time[k] == it.ntime) known = 1'b1;
    add_time = !known;
    add_ver  = (it.version_mask != '0);
    len = 16'(BASE_LEN + (add_time ? WORD_LEN : 0) + (add_ver ? WORD_LEN : 0));
    case ({add_time, add_ver})
      2'b11:   cmd = reg_copy[REG_CMD_TIME_VER];
      2'b10:   cmd = reg_copy[REG_CMD_TIME];
      2'b01:   cmd = reg_copy[REG_CMD_VER];
      default: cmd = reg_copy[REG_CMD_PLAIN];
    endcase
    queue_byte(reg_copy[REG_MAGIC]);
    queue_byte(cmd);
    queue_byte(len[7:0]);
    queue_byte(len[15:8]);
    queue_byte(it.job_id);
    queue_byte(it.link_id[7:0]);
    queue_byte(it.link_id[15:8]);
    queue_word(it.aux_nonce);
    queue_word(it.share_nonce);
    if (add_time) queue_word(it.ntime);
    if (add_ver) queue_word(it.version_mask);
    frame_q[frame_q.size()-1].last = 1'b1;
    return int'(len);
  endfunction

  // Mostly shares that hit or just miss the current history, plus notices
  function automatic submit_t rand_item();
    submit_t it;
    int      slot;
    it.op           = ($urandom_range(99) < 25) ? OP_NOTICE : OP_SHARE;
    it.job_id       = 8'($urandom);
    it.ntime        = $urandom;
    it.aux_nonce    = $urandom;
    it.share_nonce  = $urandom;
    it.link_id      = 16'($urandom);
    it.fake_job     = ($urandom_range(99) < 8);
    it.want_len     = LEN_FREE;
    case ($urandom_range(3))
      0, 1:    it.version_mask = '0;
      2:       it.version_mask = $urandom;
      default: it.version_mask = $urandom_range(1) ? '1 : (32'h1 << $urandom_range(31));
    endcase
    if (it.op == OP_SHARE && $urandom_range(99) < 55) begin
      slot = $urandom_range(HIST_DEPTH - 1);
      it.job_id = hist_job[slot];
      it.ntime  = hist_time[slot];
      // near miss: one time bit off
      if ($urandom_range(9) == 0) it.ntime = it.ntime ^ (32'h1 << $urandom_range(31));
    end
    return it;
  endfunction

  // Offer one item after a random idle gap and hold it until the transfer
  task automatic push_item(input submit_t it, output int flen);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push         <= 1'b1;
    in_opcode       <= it.op;
    in_job_id       <= it.job_id;
    in_ntime        <= it.ntime;
    in_aux_nonce    <= it.aux_nonce;
    in_share_nonce  <= it.share_nonce;
    in_version_mask <= it.version_mask;
    in_fake_job     <= it.fake_job;
    in_link_id      <= it.link_id;
    do @(posedge clk); while (in_full);
    flen = build_frame(it);
    n_items++;
    if (it.op == OP_NOTICE) n_notices++;
    else if (it.fake_job) n_fakes++;
    else n_frames++;
  endtask

  task automatic drain_frames();
    in_push <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx < NUM_REGS) reg_copy[idx] = val;
  endtask

  task automatic load_regs(input logic [7:0] magic, input logic [7:0] c_plain,
                           input logic [7:0] c_time, input logic [7:0] c_ver,
                           input logic [7:0] c_both);
    drain_frames();
    write_reg(REG_MAGIC, magic);
    write_reg(REG_CMD_PLAIN, c_plain);
    write_reg(REG_CMD_TIME, c_time);
    write_reg(REG_CMD_VER, c_ver);
    write_reg(REG_CMD_TIME_VER, c_both);
    // index past the register list: must leave everything alone
    write_reg(REG_IDX_W'($urandom_range(2**REG_IDX_W - 1, NUM_REGS)), 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic walk_table(input int lo, input int hi);
    int r;
    int flen;
    for (r = lo; r < hi; r++) begin
      push_item(dir_tab[r], flen);
      if (dir_tab[r].want_len != LEN_FREE && flen != dir_tab[r].want_len) begin
        $display("%0t: row %0d frame length expected %0d, predicted %0d",
                 $time, r, dir_tab[r].want_len, flen);
        err_cnt++;
      end
    end
  endtask

  task automatic random_run(input int n_target, input int tx_pct, input int rx_pct,
                            input int hold_at, input int pause_at);
    submit_t it;
    int      done;
    int      flen;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    done = 0;
    while (done < n_target) begin
      it = rand_item();
      push_item(it, flen);
      if (!(it.op == OP_SHARE && it.fake_job)) done++;
      if (done == hold_at) begin
        rx_hold_req = 1'b1;
        hold_at = -1;
      end
      if (done == pause_at) begin
        drain_frames();
        pause_at = -1;
      end
    end
  endtask

  // Receiver: random pop, with one long hold-off on request
  initial begin
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
      end else begin
        out_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Check every byte transfer against the oldest expected byte
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && in_push && in_full) n_stalls++;
    if (rst_n && out_pop && !out_empty) begin
      if (frame_q.size() == 0) begin
        $display("%0t: unexpected frame byte, expected none, got %h last %b",
                 $time, out_frame_byte, out_last_byte);
        err_cnt++;
      end else begin
        want = frame_q.pop_front();
        n_bytes++;
        if (out_frame_byte !== want.data) begin
          $display("%0t: frame_byte expected %h, got %h", $time, want.data, out_frame_byte);
          err_cnt++;
        end
        if (out_last_byte !== want.last) begin
          $display("%0t: last_byte expected %b, got %b", $time, want.last, out_last_byte);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int k;
    for (k = 0; k < NUM_REGS; k++) reg_copy[k] = '0;
    for (k = 0; k < HIST_DEPTH; k++) begin
      hist_job[k]  = '0;
      hist_time[k] = '0;
    end
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_push         <= 1'b0;
    in_opcode       <= OP_NOTICE;
    in_job_id       <= '0;
    in_ntime        <= '0;
    in_aux_nonce    <= '0;
    in_share_nonce  <= '0;
    in_version_mask <= '0;
    in_fake_job     <= 1'b0;
    in_link_id      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 10;
    rx_idle_pct = 52;
    walk_table(0, 2);
    load_regs(8'hA5, 8'h11, 8'h22, 8'h33, 8'h44);
    walk_table(2, DIR_ROWS);

    load_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    random_run(52, 10, 52, -1, -1);
    load_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_run(52, 52, 10, -1, 30);
    load_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    random_run(52, 0, 0, 20, -1);

    drain_frames();
    $display("Covered %0d items: %0d notices, %0d fake shares, %0d frames of %0d bytes,",
             n_items, n_notices, n_fakes, n_frames, n_bytes);
    $display("four register settings and %0d cycles of input back-pressure.", n_stalls);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### share_submit_framer.f
+incdir+rtl
rtl/sscf_pkg.sv
rtl/sscf_front.sv
rtl/sscf_queue.sv
rtl/sscf_back.sv
rtl/share_submit_framer.sv
rtl/sscf_checker.sv
tb/share_submit_framer_tb.sv
